// ===== rtl/stbs_pkg.sv =====
// Shared types and codes for the sorted table binary search block.
package stbs_pkg;

  localparam int MODE_W   = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int INDEX_W  = 10;

  // Operation codes carried by an input item.
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CHECK
  } state_t;

  // Control from the sequencer to the search bounds unit.
  typedef struct packed {
    logic start;    // load the bounds for a new search
    logic advance;  // narrow the bounds after a probe that missed
    logic go_up;    // probe was below the key: move the lower bound
  } srch_ctrl_t;

endpackage

// ===== rtl/stbs_in_if.sv =====
// Input channel: valid/ready handshake carrying mode and value.
interface stbs_in_if;
  logic                                valid;
  logic                                ready;
  logic [stbs_pkg::MODE_W-1:0]         mode;
  logic signed [stbs_pkg::VALUE_W-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

// ===== rtl/stbs_out_if.sv =====
// Result channel: valid/ready handshake carrying status and index.
interface stbs_out_if;
  logic                          valid;
  logic                          ready;
  logic [stbs_pkg::STATUS_W-1:0] status;
  logic [stbs_pkg::INDEX_W-1:0]  index;

  modport source (output valid, output status, output index, input ready);
  modport sink   (input valid, input status, input index, output ready);
endinterface

// ===== rtl/stbs_bounds.sv =====
// Search bounds unit: lower and exclusive upper bound, midpoint and narrowing step.
module stbs_bounds #(
  parameter int CW = 11
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  stbs_pkg::srch_ctrl_t ctrl,
  input  logic [CW-1:0]        count,
  output logic [CW-1:0]        mid,
  output logic                 exhausted
);
  import stbs_pkg::*;

  logic [CW-1:0] lo_r, lo_nxt;
  logic [CW-1:0] hi_r, hi_nxt;   // one past the last candidate
  logic [CW-1:0] span;

  // The range is [lo, hi); the midpoint rounds down like lo + (hi_incl - lo) / 2.
  assign exhausted = !(lo_r < hi_r);
  assign span      = hi_r - lo_r - CW'(1);
  assign mid       = lo_r + (span >> 1);

  always_comb begin
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    if (ctrl.start) begin
      lo_nxt = '0;
      hi_nxt = count;
    end else if (ctrl.advance) begin
      if (ctrl.go_up) begin
        lo_nxt = mid + CW'(1);
      end else begin
        hi_nxt = mid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r <= '0;
      hi_r <= '0;
    end else begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
  end

endmodule

// ===== rtl/sorted_table_binary_search_core.sv =====
// Top level of the sorted table binary search block: table memory, sequencer, result register.
//
// The block keeps a table of signed 32-bit entries that the loader appends in
// ascending order. Each transfer on in_ch carries a mode and a value; each one
// produces exactly one transfer on out_ch with a status and an index.
// Clear sets the entry count to zero (contents are kept), append writes the
// next entry or reports full, and search runs a binary search over the loaded
// entries and returns the matching index or not-found. An unused mode gives ok.
// Clear, append and the unused mode present their result one cycle after the
// input transfer. A search steps through a probe state (a registered memory
// read of the midpoint) and a check state (the compare, then the bound update
// in the bounds unit) for each probe, and ends on a match or when a probe finds
// the range exhausted. Only one item is in work at a time: in_ch.ready
// is high only while the sequencer is idle and the result register is empty
// or being emptied in the same cycle. If the receiver stalls, the result holds
// in the output register and no new input is taken. Reset (synchronous,
// active low) empties the table count and the result register; the memory is
// not cleared, which is harmless because a search only reads loaded entries.
module sorted_table_binary_search_core #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  stbs_in_if.sink   in_ch,
  stbs_out_if.source out_ch
);
  import stbs_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  state_t state_r, state_nxt;

  logic [CW-1:0]               count_r, count_nxt;
  logic signed [VALUE_W-1:0]   key_r, key_nxt;
  logic signed [VALUE_W-1:0]   mem [TABLE_DEPTH];
  logic signed [VALUE_W-1:0]   rd_data_r;

  logic                        out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]         out_status_r, out_status_nxt;
  logic [INDEX_W-1:0]          out_index_r, out_index_nxt;

  logic                        in_xfer;
  logic                        wr_en;
  logic                        res_load;
  logic [STATUS_W-1:0]         res_status;
  logic [INDEX_W-1:0]          res_index;

  srch_ctrl_t                  ctrl;
  logic [CW-1:0]               mid;
  logic                        exhausted;

  stbs_bounds #(.CW(CW)) u_bounds (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .count     (count_r),
    .mid       (mid),
    .exhausted (exhausted)
  );

  // A new item is taken only when idle and the result register is empty or being emptied.
  assign in_ch.ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // Sequencer: decodes the incoming item and steps the search probe by probe.
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    key_nxt      = key_r;
    wr_en        = 1'b0;
    res_load     = 1'b0;
    res_status   = STATUS_OK;
    res_index    = '0;
    ctrl.start   = 1'b0;
    ctrl.advance = 1'b0;
    ctrl.go_up   = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          unique case (in_ch.mode)
            MODE_CLEAR: begin
              count_nxt = '0;
              res_load  = 1'b1;
            end
            MODE_APPEND: begin
              res_load = 1'b1;
              if (count_r == CW'(TABLE_DEPTH)) begin
                res_status = STATUS_FULL;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end
            MODE_SEARCH: begin
              key_nxt    = in_ch.value;
              ctrl.start = 1'b1;
              state_nxt  = ST_PROBE;
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      ST_PROBE: begin
        // The memory read of the midpoint is issued in this cycle.
        if (exhausted) begin
          res_load   = 1'b1;
          res_status = STATUS_NOT_FOUND;
          state_nxt  = ST_IDLE;
        end else begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (rd_data_r == key_r) begin
          res_load  = 1'b1;
          res_index = INDEX_W'(mid);
          state_nxt = ST_IDLE;
        end else begin
          ctrl.advance = 1'b1;
          ctrl.go_up   = rd_data_r < key_r;
          state_nxt    = ST_PROBE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result register: loaded with one result, emptied by a transfer on out_ch.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_index_nxt  = out_index_r;
    if (res_load) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status;
      out_index_nxt  = res_index;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.index  = out_index_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    out_status_r <= out_status_nxt;
    out_index_r  <= out_index_nxt;
  end

  // Table memory: one write port for appends, one registered read port for probes.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[AW-1:0]] <= in_ch.value;
    end
    rd_data_r <= mem[mid[AW-1:0]];
  end

endmodule
